// ===== hw/rtl/i2da_pkg.sv =====
package i2da_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [3:0] MSD_POS     = 4'd9;
    localparam int         MAG_W       = 32;
    localparam int         EXT_W       = 34;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step_digit;
    } i2da_cmd_t;

    typedef struct packed {
        logic out_free;
        logic pos_zero;
        logic neg;
    } i2da_sts_t;

    // power of ten for a decimal position, wide enough for nine times 10^9
    function automatic logic [EXT_W-1:0] pow10(input logic [3:0] k);
        logic [EXT_W-1:0] p;
        case (k)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/i2da_datapath.sv =====
module i2da_datapath
    import i2da_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      value,
    input  i2da_cmd_t        cmd,
    output i2da_sts_t        sts,
    output logic [7:0]       character,
    output logic             last,
    output logic             out_valid,
    input  logic             out_stall
);

    logic [MAG_W-1:0] mag_reg;
    logic [3:0]       pos_reg;
    logic             neg_reg;
    logic             started_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [EXT_W-1:0] pow;
    logic [EXT_W-1:0] mult [1:9];
    logic [9:1]       ge;
    logic [3:0]       digit;
    logic [EXT_W-1:0] sub;
    logic [EXT_W-1:0] rem;
    logic             out_free;
    logic             show;

    assign pow = pow10(pos_reg);

    // compare the magnitude against every multiple of the current power at once
    always_comb
    begin
        digit = 4'd0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            mult[d] = pow * EXT_W'(d);
            ge[d]   = {2'b00, mag_reg} >= mult[d];
            if (ge[d])
            begin
                digit = 4'(d);
                sub   = mult[d];
            end
        end
        rem = {2'b00, mag_reg} - sub;
    end

    assign out_free = !out_valid_reg || !out_stall;
    // leading zeros are dropped, the units digit always shows
    assign show     = (digit != 4'd0) || started_reg || (pos_reg == 4'd0);

    // a held word stays until taken, a new one replaces it
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_sign || (cmd.step_digit && show))
            out_valid_next = 1'b1;
    end

    assign sts.out_free = out_free;
    assign sts.pos_zero = (pos_reg == 4'd0);
    assign sts.neg      = neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            pos_reg       <= MSD_POS;
            neg_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                neg_reg     <= value[31];
                pos_reg     <= MSD_POS;
                started_reg <= 1'b0;
            end
            else if (cmd.step_digit)
            begin
                pos_reg <= pos_reg - 4'd1;
                if (show)
                    started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mag_reg <= value[31] ? (32'd0 - value) : value;
        else if (cmd.emit_sign)
        begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.step_digit)
        begin
            mag_reg <= rem[MAG_W-1:0];
            if (show)
            begin
                char_reg <= ASCII_ZERO + {4'd0, digit};
                last_reg <= (pos_reg == 4'd0);
            end
        end
    end

    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/i2da_ctrl.sv =====
module i2da_ctrl
    import i2da_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  i2da_sts_t sts,
    output i2da_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.emit_sign  = 1'b0;
        cmd.step_digit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!sts.neg)
                    state_next = ST_DIGITS;
                else if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (sts.out_free)
                begin
                    cmd.step_digit = 1'b1;
                    if (sts.pos_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/int_to_decimal_ascii_top.sv =====
// signed 32-bit integer to decimal ascii text
// input channel: value with in_valid / in_stall; a word is taken when
//   in_valid is high and in_stall is low at a rising clock edge
// output channel: character and last with out_valid / out_stall, one
//   ascii character per word, most significant first, '-' before a
//   negative number, no leading zeros, last set on the units digit
// one number at a time: after a word is taken, the sign state decides
//   the sign, then the ten decimal positions are walked from 10^9 down to
//   10^0, one position per cycle while the output register is free, all
//   nine multiples of the power compared in parallel; the input takes no
//   new word until the units digit is registered, and short numbers give
//   their first character later since skipped leading zeros still cost
//   a step each
// the output register lets the next number be taken while the final
//   character still waits
// a receiver stall freezes the walk until the output register frees up
// asynchronous reset clears the controller and the output valid flag
module int_to_decimal_ascii_top
    import i2da_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  character,
    output logic        last
);

    i2da_cmd_t cmd;
    i2da_sts_t sts;

    i2da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2da_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // a taken word locks the input until its last character is in the output register
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not locked after accept");

    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == ASCII_MINUS) ||
                      ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9)))
        else $error("illegal output character");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (character == ASCII_MINUS)) |-> !last)
        else $error("minus sign flagged as last");

    // a sign is always followed by a digit, never another sign
    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (character == ASCII_MINUS)) |=>
        !(out_valid && (character == ASCII_MINUS)))
        else $error("two signs in a row");

endmodule

// ===== tb/tb_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 100ps

module tb_int_to_decimal_ascii_top;
    import i2da_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  character;
    logic        last;

    typedef struct {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    class decimal_text_board;
        text_char_t pending_chars[$];
        int         mismatches;
        int         numbers_seen;
        int         chars_checked;

        function new();
            mismatches    = 0;
            numbers_seen  = 0;
            chars_checked = 0;
        endfunction

        // decimal text of one accepted word, sign first, units digit last
        function void note_value(logic [31:0] raw);
            logic [31:0] mag;
            logic [3:0]  digits [10];
            int          nd;
            int          i;
            text_char_t  c;
            numbers_seen++;
            mag = raw[31] ? (32'd0 - raw) : raw;
            nd  = 0;
            do
            begin
                digits[nd] = 4'(mag % 32'd10);
                mag        = mag / 32'd10;
                nd++;
            end while (mag != 0 && nd < 10);
            if (raw[31])
            begin
                c.character = ASCII_MINUS;
                c.last      = 1'b0;
                pending_chars.push_back(c);
            end
            for (i = nd; i > 0; i--)
            begin
                c.character = ASCII_ZERO + {4'd0, digits[i-1]};
                c.last      = (i == 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic fin);
            text_char_t want;
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word: character %h last %b", $time, ch, fin);
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.character || fin !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected character %h last %b, got %h last %b",
                             $time, want.character, want.last, ch, fin);
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    decimal_text_board board;
    int                send_idle_pct;
    int                recv_stall_pct;

    int directed_values [] = '{
        0, 1, -1, 5, -9, 9, 10, -10, 99, 100,
        2147483647, int'(32'h8000_0000), -2147483647,
        1000000000, 999999999, 1999999999, 2000000000, -1000000000,
        12345, -987654321, 1234567890, int'(32'h5555_5555), int'(32'hAAAA_AAAA)
    };

    int_to_decimal_ascii_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_value(value);
            if (out_valid && !out_stall)
                board.check_char(character, last);
        end
    end

    // holds the word until it is taken; idle cycles go in front of it
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            value    <= $urandom;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random(input int count);
        logic [63:0] p;
        logic [63:0] hi;
        logic [31:0] mag;
        logic [31:0] v;
        int          sel;
        int          k;
        repeat (count)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 40)
                v = $urandom;
            else
            begin
                k = $urandom_range(10, 1);
                p = 64'd1;
                repeat (k - 1) p = p * 64'd10;
                if (sel < 90)
                begin
                    hi = p * 64'd10 - 64'd1;
                    if (hi > 64'd2147483647)
                        hi = 64'd2147483647;
                    mag = $urandom_range(hi[31:0], p[31:0]);
                end
                else
                    mag = $urandom_range(1, 0) ? p[31:0] : p[31:0] - 32'd1;
                v = $urandom_range(1, 0) ? (32'd0 - mag) : mag;
                // the two ends of the range now and then
                if (sel >= 97)
                    v = $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            send_value(v);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
    endtask

    initial
    begin
        int guard;
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = 32'd0;
        out_stall      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_values[i])
            send_value(directed_values[i]);

        run_phase(0, 0, 62);
        run_phase(86, 0, 62);
        run_phase(0, 86, 62);
        run_phase(9, 9, 62);

        @(negedge clk);
        in_valid <= 1'b0;

        guard = 0;
        while (board.outstanding() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);

        $display("converted %0d numbers, checked %0d characters across four idle/stall phases",
                 board.numbers_seen, board.chars_checked);
        $display("mismatches %0d, characters still expected %0d",
                 board.mismatches, board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("int_to_decimal_ascii_top test passed");
        else
            $display("int_to_decimal_ascii_top test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("int_to_decimal_ascii_top test failed");
        $finish;
    end

endmodule
